// ===== hw/rtl/nb2d_pkg.sv =====
// Package: constants and stage types for the binary128 to binary64 narrowing core.
`timescale 1ns / 1ps
package nb2d_pkg;
  localparam logic [14:0] QEXP_ALL = 15'h7FFF;
  localparam logic [10:0] DEXP_ALL = 11'h7FF;
  // biased quad exponent of 2^-1022 and 2^1023
  localparam logic [14:0] QEXP_DMIN = 15'd15361;
  localparam logic [14:0] QEXP_DMAX = 15'd17406;
  localparam logic [7:0]  NORM_DROP = 8'd60;
  localparam logic [7:0]  MAX_DROP  = 8'd113;

  // stage 1 -> stage 2: classified operand and shift amount
  typedef struct packed {
    logic        sign;
    logic        special;   // result fully decided in stage 1
    logic [63:0] spec_bits;
    logic        normal;
    logic [14:0] qexp;
    logic [6:0]  drop;      // 60..113
    logic [112:0] sig;
  } st1_t;

  // stage 2 -> stage 3: shifted mantissa with rounding bits
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [63:0] spec_bits;
    logic        normal;
    logic [10:0] dexp;
    logic [52:0] mant;
    logic        guard;
    logic        sticky;
  } st2_t;
endpackage

// ===== hw/rtl/narrow_binary128_to_binary64_core.sv =====
// Top level: three-stage pipelined binary128 to binary64 narrowing, round to nearest even.
`timescale 1ns / 1ps
// Channel | Ports                          | Dir | Handshake
// request | in_quad_high, in_quad_low      | in  | start & !busy
// result  | out_double_bits                | out | out_valid, one cycle
// One request is taken every cycle. Its result passes through the classify,
// shift and round register stages (s1_r, s2_r, res_r) in that order before
// it reaches the outputs.
// busy is tied low: the receiver cannot stall, so nothing ever backs up.
// Synchronous active-low reset clears the stage valid bits only.
module narrow_binary128_to_binary64_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_quad_high,
  input  logic [63:0] in_quad_low,
  output logic        out_valid,
  output logic [63:0] out_double_bits
);
  import nb2d_pkg::*;

  logic v1_r, v2_r, v3_r;
  nb2d_pkg::st1_t s1_nxt, s1_r;
  nb2d_pkg::st2_t s2_nxt, s2_r;
  logic [63:0] res_nxt, res_r;

  assign busy = 1'b0;

  // stage 1: classify and compute shift
  always_comb begin
    logic [14:0] qe;
    logic [47:0] fhi;
    logic [51:0] nf;
    logic [15:0] dr;
    qe  = in_quad_high[62:48];
    fhi = in_quad_high[47:0];
    nf  = {fhi, in_quad_low[63:60]};
    s1_nxt.sign = in_quad_high[63];
    s1_nxt.sig  = {1'b1, fhi, in_quad_low};
    s1_nxt.qexp = qe;
    s1_nxt.special = 1'b1;
    s1_nxt.spec_bits = {in_quad_high[63], 63'd0};
    s1_nxt.normal = (qe >= QEXP_DMIN);
    dr = s1_nxt.normal ? {8'd0, NORM_DROP}
                       : 16'({8'd0, NORM_DROP}) + 16'(QEXP_DMIN - qe);
    s1_nxt.drop = 7'(dr);
    if (qe == QEXP_ALL) begin
      if (fhi == 48'd0 && in_quad_low == 64'd0)
        s1_nxt.spec_bits = {in_quad_high[63], DEXP_ALL, 52'd0};
      else
        s1_nxt.spec_bits = {in_quad_high[63], DEXP_ALL, (nf == 52'd0) ? 52'd1 : nf};
    end else if (qe == 15'd0) begin
      s1_nxt.special = 1'b1;
    end else if (qe > QEXP_DMAX) begin
      s1_nxt.spec_bits = {in_quad_high[63], DEXP_ALL, 52'd0};
    end else if (dr > {8'd0, MAX_DROP}) begin
      s1_nxt.special = 1'b1;
    end else begin
      s1_nxt.special = 1'b0;
    end
  end

  // stage 2: align mantissa, extract guard and sticky
  always_comb begin
    logic [112:0] sh, msk;
    logic [6:0] g;
    g  = s1_r.drop - 7'd1;
    sh = s1_r.sig >> s1_r.drop;
    msk = ~({113{1'b1}} << g);
    s2_nxt.sign = s1_r.sign;
    s2_nxt.special = s1_r.special;
    s2_nxt.spec_bits = s1_r.spec_bits;
    s2_nxt.normal = s1_r.normal;
    s2_nxt.dexp = 11'(s1_r.qexp - 15'd15360);
    s2_nxt.mant = {1'b0, sh[51:0]};
    s2_nxt.guard = s1_r.sig[g];
    s2_nxt.sticky = |(s1_r.sig & msk);
  end

  // stage 3: round and pack
  always_comb begin
    logic [52:0] m;
    logic [11:0] e;
    m = s2_r.mant + {52'd0, s2_r.guard & (s2_r.sticky | s2_r.mant[0])};
    e = s2_r.normal ? {1'b0, s2_r.dexp} : 12'd0;
    if (m[52]) e = e + 12'd1;
    if (s2_r.special) res_nxt = s2_r.spec_bits;
    else if (e >= 12'h7FF) res_nxt = {s2_r.sign, DEXP_ALL, 52'd0};
    else res_nxt = {s2_r.sign, e[10:0], m[51:0]};
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = v3_r;
  assign out_double_bits = res_r;
endmodule
